// ===== src/brle_pkg.sv =====
// Shared types and constants for the byte run-length encoder.
// No dependencies; used by every module under src.
`default_nettype none

package brle_pkg;

  // Fixed widths of the stream fields
  localparam int unsigned FIELD_W = 8;
  localparam int unsigned TDATA_IN_W = 8;
  localparam int unsigned TDATA_OUT_W = 16;

  // Defaults for the top-level parameters
  localparam int unsigned SAMPLE_WIDTH_DEF = 8;
  localparam int unsigned COUNT_LIMIT_DEF = 255;

  // Largest repeat count that fits the output field
  localparam int unsigned COUNT_FIELD_MAX = 255;

  // Result queue geometry
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // One encoded pair as it leaves the block
  typedef struct packed {
    logic               stream_end;
    logic [FIELD_W-1:0] run_value;
    logic [FIELD_W-1:0] repeat_count;
  } pair_t;

  // Push strobes from the run tracker into the result queue
  typedef struct packed {
    logic push0;
    logic push1;
  } push_t;

endpackage

`default_nettype wire

// ===== src/byte_run_length_encoder.sv =====
// Byte run-length encoder, top level.
// Depends on brle_pkg, brle_in_stage, brle_run_track and brle_out_queue.
//
// Usage:
//   Input channel in_*: one sample word per transfer, in_tlast on the final
//   sample of a stream. Output channel out_*: one (repeat_count, run_value)
//   word per transfer, repeat_count being run length minus one; out_tlast
//   marks the final word of a stream.
//   A sample that differs from the open run, or arrives with the run already
//   at the count limit, closes that run and emits one word. A last sample also
//   flushes the open run, so it may emit two words.
// Path: a word emitted by a sample is offered on out_* once that sample has
//   passed the input register and been written into the result queue.
// Throughput: one sample per cycle while the result queue has room for two
//   words; the output drains one word per cycle while out_tready is high, so
//   only a last sample that closes a run emits two words for one sample.
// Reset (rst_n low, synchronous): no run open, input stage and queue empty.
// Receiver stall: the four-word result queue absorbs words; the input stage
//   holds its sample until the queue has space for two words, and in_tready
//   drops once the held sample cannot move on.
`default_nettype none

module byte_run_length_encoder #(
  parameter int unsigned SAMPLE_WIDTH = brle_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned COUNT_LIMIT  = brle_pkg::COUNT_LIMIT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [brle_pkg::TDATA_IN_W-1:0]   in_tdata,   // [7:0] sample
  input  wire logic                              in_tlast,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [brle_pkg::TDATA_OUT_W-1:0]       out_tdata,  // [7:0] repeat_count, [15:8] run_value
  output logic                                   out_tlast   // stream_end
);

  logic                          room;
  logic                          item_vld;
  logic [brle_pkg::FIELD_W-1:0]  item_sample;
  logic                          item_last;
  brle_pkg::push_t               push;
  brle_pkg::pair_t               pair0;
  brle_pkg::pair_t               pair1;
  brle_pkg::pair_t               out_pair;

  // Register the incoming sample
  brle_in_stage u_in_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_sample   (in_tdata[brle_pkg::FIELD_W-1:0]),
    .in_last     (in_tlast),
    .room        (room),
    .item_vld    (item_vld),
    .item_sample (item_sample),
    .item_last   (item_last)
  );

  // Advance the run and form the closed and flushed pairs
  brle_run_track #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COUNT_LIMIT  (COUNT_LIMIT)
  ) u_run_track (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_vld    (item_vld),
    .item_sample (item_sample),
    .item_last   (item_last),
    .push        (push),
    .pair0       (pair0),
    .pair1       (pair1)
  );

  // Queue pairs towards the output channel
  brle_out_queue u_out_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pair0      (pair0),
    .pair1      (pair1),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_pair   (out_pair)
  );

  assign out_tdata = {out_pair.run_value, out_pair.repeat_count};
  assign out_tlast = out_pair.stream_end;

endmodule

`default_nettype wire

// ===== src/brle_in_stage.sv =====
// Input register stage of the byte run-length encoder.
// Depends on brle_pkg for field widths.
`default_nettype none

module brle_in_stage (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [brle_pkg::FIELD_W-1:0] in_sample,
  input  wire logic                        in_last,
  input  wire logic                        room,
  output logic                             item_vld,
  output logic [brle_pkg::FIELD_W-1:0]     item_sample,
  output logic                             item_last
);

  logic                          vld_r;
  logic [brle_pkg::FIELD_W-1:0]  sample_r;
  logic                          last_r;
  logic                          adv;

  // Stage empties whenever the queue can take both pairs of the held word
  assign adv       = vld_r && room;
  assign in_tready = !vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_tready) begin
      vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      sample_r <= in_sample;
      last_r   <= in_last;
    end
  end

  assign item_vld    = adv;
  assign item_sample = sample_r;
  assign item_last   = last_r;

endmodule

`default_nettype wire

// ===== src/brle_run_track.sv =====
// Run state and pair generation for the byte run-length encoder.
// Depends on brle_pkg for pair_t, push_t and widths.
`default_nettype none

module brle_run_track #(
  parameter int unsigned SAMPLE_WIDTH = brle_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned COUNT_LIMIT  = brle_pkg::COUNT_LIMIT_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        item_vld,
  input  wire logic [brle_pkg::FIELD_W-1:0] item_sample,
  input  wire logic                        item_last,
  output brle_pkg::push_t                  push,
  output brle_pkg::pair_t                  pair0,
  output brle_pkg::pair_t                  pair1
);

  localparam int unsigned VAL_W = (SAMPLE_WIDTH < brle_pkg::FIELD_W) ?
                                  SAMPLE_WIDTH : brle_pkg::FIELD_W;
  localparam int unsigned RUN_LIMIT = (COUNT_LIMIT > brle_pkg::COUNT_FIELD_MAX) ?
                                      brle_pkg::COUNT_FIELD_MAX : COUNT_LIMIT;
  localparam int unsigned CNT_W = $clog2(RUN_LIMIT + 1);

  logic             open_r,  open_nxt;
  logic [VAL_W-1:0] cur_r,   cur_nxt;
  logic [CNT_W-1:0] cnt_r,   cnt_nxt;
  logic [VAL_W-1:0] smp;
  logic             close_run;
  logic [VAL_W-1:0] run_val;
  logic [CNT_W-1:0] run_cnt;

  assign smp = item_sample[VAL_W-1:0];

  // Step the open run by one sample
  always_comb begin
    close_run = 1'b0;
    run_val   = cur_r;
    run_cnt   = cnt_r;
    if (!open_r) begin
      run_val = smp;
      run_cnt = '0;
    end else if (smp == cur_r && cnt_r < CNT_W'(RUN_LIMIT)) begin
      run_cnt = cnt_r + CNT_W'(1);
    end else begin
      close_run = 1'b1;
      run_val   = smp;
      run_cnt   = '0;
    end
  end

  // Closed run goes first, the flush on a last word after it
  always_comb begin
    pair0.repeat_count = brle_pkg::FIELD_W'(cnt_r);
    pair0.run_value    = brle_pkg::FIELD_W'(cur_r);
    pair0.stream_end   = 1'b0;
    pair1.repeat_count = brle_pkg::FIELD_W'(run_cnt);
    pair1.run_value    = brle_pkg::FIELD_W'(run_val);
    pair1.stream_end   = 1'b1;
    push.push0 = 1'b0;
    push.push1 = 1'b0;
    if (item_vld) begin
      if (close_run) begin
        push.push0 = 1'b1;
        push.push1 = item_last;
      end else if (item_last) begin
        pair0      = pair1;
        push.push0 = 1'b1;
      end
    end
  end

  always_comb begin
    open_nxt = open_r;
    cur_nxt  = cur_r;
    cnt_nxt  = cnt_r;
    if (item_vld) begin
      if (item_last) begin
        open_nxt = 1'b0;
        cur_nxt  = '0;
        cnt_nxt  = '0;
      end else begin
        open_nxt = 1'b1;
        cur_nxt  = run_val;
        cnt_nxt  = run_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      cur_r  <= '0;
      cnt_r  <= '0;
    end else begin
      open_r <= open_nxt;
      cur_r  <= cur_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/brle_out_queue.sv =====
// Result queue of the byte run-length encoder: takes up to two pairs a cycle.
// Depends on brle_pkg for pair_t, push_t and queue geometry.
`default_nettype none

module brle_out_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire brle_pkg::push_t push,
  input  wire brle_pkg::pair_t pair0,
  input  wire brle_pkg::pair_t pair1,
  output logic                 room,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output brle_pkg::pair_t      out_pair
);

  localparam int unsigned PW = brle_pkg::QUEUE_PTR_W;
  localparam int unsigned CW = brle_pkg::QUEUE_CNT_W;

  brle_pkg::pair_t mem_r [brle_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   head_r, head_nxt;
  logic [PW-1:0]   tail_r, tail_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            pop;
  logic [CW:0]     free_after;

  assign out_tvalid = (count_r != '0);
  assign out_pair   = mem_r[head_r];
  assign pop        = out_tvalid && out_tready;

  // Hold the upstream word unless both of its pairs fit after this pop
  assign free_after = (CW+1)'(brle_pkg::QUEUE_DEPTH) - (CW+1)'(count_r) + (CW+1)'(pop);
  assign room       = (free_after >= (CW+1)'(2));

  always_comb begin
    head_nxt  = head_r + PW'(pop);
    tail_nxt  = tail_r + PW'(push.push0) + PW'(push.push1);
    count_nxt = count_r + CW'(push.push0) + CW'(push.push1) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem_r[tail_r] <= pair0;
    end
    if (push.push1) begin
      mem_r[tail_r + PW'(1)] <= pair1;
    end
  end

endmodule

`default_nettype wire

// ===== verif/tb_byte_run_length_encoder.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for byte_run_length_encoder: a directed table of samples, then
// random sample streams, each word checked against a typed row or run-tracking predictor.
// Depends on brle_pkg and the encoder RTL under src.

module tb_byte_run_length_encoder;

  // Longest run the encoder may count before it must close the run
  localparam int unsigned RUN_LIMIT =
    (brle_pkg::COUNT_LIMIT_DEF > brle_pkg::COUNT_FIELD_MAX) ?
    brle_pkg::COUNT_FIELD_MAX : brle_pkg::COUNT_LIMIT_DEF;

  localparam int TARGET_SAMPLES = 1550;
  localparam int CALM_AFTER     = 1350;  // no idling on either side beyond this many samples
  localparam int HOLD_CYCLES    = 48;    // long receiver hold-off, enough to fill the queue
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no word moving on either side
  localparam int MAX_REPORTS    = 10;
  localparam int NUM_DIR        = 20;

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [brle_pkg::TDATA_IN_W-1:0]  in_tdata   = '0;   // [7:0] sample
  logic                             in_tlast   = 1'b0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [brle_pkg::TDATA_OUT_W-1:0] out_tdata;         // [7:0] repeat_count, [15:8] run_value
  logic                             out_tlast;         // stream_end

  // One row of the directed table; typed rows carry their expected words
  typedef struct {
    logic [7:0]      sample;
    bit              last;
    bit              typed;
    int              n;
    brle_pkg::pair_t p0;
    brle_pkg::pair_t p1;
  } dir_row_t;

  // Expected words are packed as {stream_end, run_value, repeat_count}
  dir_row_t dir_rows [NUM_DIR] = '{
    '{8'h00, 1'b1, 1'b1, 1, {1'b1, 8'h00, 8'h00}, '0},  // single-sample stream, all zeros
    '{8'hFF, 1'b1, 1'b1, 1, {1'b1, 8'hFF, 8'h00}, '0},  // single-sample stream, all ones
    '{8'hA5, 1'b0, 1'b1, 0, '0, '0},                    // first sample opens a run silently
    '{8'hA5, 1'b0, 1'b0, 0, '0, '0},
    '{8'h5A, 1'b0, 1'b0, 0, '0, '0},
    '{8'h5A, 1'b1, 1'b0, 0, '0, '0},
    '{8'h01, 1'b0, 1'b0, 0, '0, '0},
    '{8'h02, 1'b1, 1'b0, 0, '0, '0},                    // last sample closes a run: two words
    '{8'h80, 1'b0, 1'b0, 0, '0, '0},
    '{8'h7F, 1'b0, 1'b0, 0, '0, '0},
    '{8'h7F, 1'b0, 1'b0, 0, '0, '0},
    '{8'h7F, 1'b1, 1'b0, 0, '0, '0},
    '{8'h55, 1'b0, 1'b0, 0, '0, '0},
    '{8'hAA, 1'b0, 1'b0, 0, '0, '0},
    '{8'h55, 1'b0, 1'b0, 0, '0, '0},
    '{8'hAA, 1'b1, 1'b0, 0, '0, '0},
    '{8'h00, 1'b0, 1'b0, 0, '0, '0},
    '{8'h00, 1'b0, 1'b0, 0, '0, '0},
    '{8'hFF, 1'b0, 1'b0, 0, '0, '0},
    '{8'hFF, 1'b1, 1'b0, 0, '0, '0}
  };

  // Predictor state, mirroring the encoder's run tracker
  bit         trk_open  = 1'b0;
  logic [7:0] trk_value = '0;
  logic [7:0] trk_extra = '0;

  brle_pkg::pair_t pending_pairs [$];

  int  errors       = 0;
  int  samples_sent = 0;
  int  streams_done = 0;
  int  pairs_seen   = 0;
  int  limit_splits = 0;
  int  quiet_cycles = 0;
  bit  calm         = 1'b0;
  bit  tx_gaps      = 1'b0;
  bit  hold_req     = 1'b0;
  bit  hold_done    = 1'b0;
  int  hold_left    = 0;
  int  stall_left   = 0;
  bit  rx_stalls    = 1'b1;
  int  rx_cycle     = 0;

  byte_run_length_encoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Advance the run tracker by one sample and return the words it closes
  function automatic int encode_sample(input logic [7:0] s, input bit is_last,
                                       output brle_pkg::pair_t r0,
                                       output brle_pkg::pair_t r1);
    int n;
    n  = 0;
    r0 = '0;
    r1 = '0;
    if (!trk_open) begin
      trk_open  = 1'b1;
      trk_value = s;
      trk_extra = '0;
    end else if (s == trk_value && trk_extra < RUN_LIMIT) begin
      trk_extra = trk_extra + 8'd1;
    end else begin
      if (s == trk_value) limit_splits++;
      r0        = {1'b0, trk_value, trk_extra};
      n         = 1;
      trk_value = s;
      trk_extra = '0;
    end
    if (is_last) begin
      if (n == 0) r0 = {1'b1, trk_value, trk_extra};
      else        r1 = {1'b1, trk_value, trk_extra};
      n++;
      trk_open  = 1'b0;
      trk_value = '0;
      trk_extra = '0;
    end
    return n;
  endfunction

  task automatic report_error(input string what);
    errors++;
    if (errors <= MAX_REPORTS) $display("%s", what);
  endtask

  // Offer one sample word, hold it until taken, then queue the words it should close
  task automatic send_sample(input logic [7:0] s, input bit is_last, input bit use_typed,
                             input int tn, input brle_pkg::pair_t t0,
                             input brle_pkg::pair_t t1);
    brle_pkg::pair_t r0;
    brle_pkg::pair_t r1;
    int              n;
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    in_tlast  <= is_last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n = encode_sample(s, is_last, r0, r1);
    if (use_typed) begin
      n  = tn;
      r0 = t0;
      r1 = t1;
    end
    if (n > 0) pending_pairs = {pending_pairs, r0};
    if (n > 1) pending_pairs = {pending_pairs, r1};
    samples_sent++;
    if (is_last) streams_done++;
    if (tx_gaps && !calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_run(input logic [7:0] v, input int len, input bit close_stream);
    int i;
    for (i = 0; i < len; i++)
      send_sample(v, close_stream && (i == len - 1), 1'b0, 0, '0, '0);
  endtask

  // Drop the input and wait until every queued word has been taken
  task automatic drain_outputs();
    in_tvalid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stall bursts, one long hold-off on request, none once calm
  always @(posedge clk) begin
    rx_cycle++;
    if (rx_cycle % 64 == 0) rx_stalls = ($urandom_range(0, 2) != 0);
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (rx_stalls && !calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 5);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Check every taken output word against the oldest expectation
  always @(posedge clk) begin
    brle_pkg::pair_t want;
    if (rst_n && out_tvalid && out_tready) begin
      pairs_seen++;
      if (pending_pairs.size() == 0) begin
        report_error($sformatf("unexpected word: count %0d value 0x%02h end %0b",
                               out_tdata[7:0], out_tdata[15:8], out_tlast));
      end else begin
        want = pending_pairs.pop_front();
        if (out_tdata[7:0] !== want.repeat_count || out_tdata[15:8] !== want.run_value ||
            out_tlast !== want.stream_end)
          report_error($sformatf(
            "word mismatch: expected count %0d value 0x%02h end %0b, got %0d 0x%02h %0b",
            want.repeat_count, want.run_value, want.stream_end,
            out_tdata[7:0], out_tdata[15:8], out_tlast));
      end
    end
  end

  // Watchdog: stop the run if no word moves on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d words outstanding",
               quiet_cycles, pending_pairs.size());
      $display("tb_byte_run_length_encoder: done, errors");
      $finish;
    end
  end

  initial begin
    int         i;
    int         k;
    int         runs;
    int         len;
    int         pick;
    int         stream_no;
    logic [7:0] v;
    stream_no = 0;
    v         = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: extremes, single-sample streams, two-word flushes
    for (i = 0; i < NUM_DIR; i++)
      send_sample(dir_rows[i].sample, dir_rows[i].last, dir_rows[i].typed,
                  dir_rows[i].n, dir_rows[i].p0, dir_rows[i].p1);
    drain_outputs();

    // Random part: mostly well-formed streams of runs, some noise
    while (samples_sent < TARGET_SAMPLES) begin
      stream_no++;
      calm    = (samples_sent >= CALM_AFTER);
      tx_gaps = !calm && ($urandom_range(0, 2) != 0);
      if (stream_no == 2) begin
        // 256 equal samples fill the count exactly; 257 force a split at the limit
        v = 8'($urandom);
        send_run(v, 256, 1'b0);
        send_run(~v, 257, 1'b1);
      end else if (stream_no == 4) begin
        // hold the receiver off while every sample closes a run, so the input backs up
        tx_gaps  = 1'b0;
        hold_req = 1'b1;
        for (k = 0; k < 40; k++)
          send_sample(8'(k * 37 + 11), k == 39, 1'b0, 0, '0, '0);
      end else if (stream_no == 6) begin
        drain_outputs();
      end else if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(1, 16);
        for (k = 0; k < len; k++)
          send_sample(8'($urandom), $urandom_range(0, 7) == 0, 1'b0, 0, '0, '0);
      end else begin
        runs = $urandom_range(1, 10);
        for (k = 0; k < runs; k++) begin
          pick = $urandom_range(0, 7);
          // keeping the previous value lengthens the open run across calls
          if (pick == 1)      v = 8'h00;
          else if (pick == 2) v = 8'hFF;
          else if (pick > 2)  v = 8'($urandom);
          pick = $urandom_range(0, 59);
          if (pick == 0)     len = $urandom_range(250, 300);
          else if (pick < 10) len = $urandom_range(9, 40);
          else                len = $urandom_range(1, 8);
          send_run(v, len, k == runs - 1);
        end
      end
    end

    drain_outputs();
    repeat (8) @(posedge clk);

    $display("covered %0d samples, %0d closed streams, %0d words checked",
             samples_sent, streams_done, pairs_seen);
    $display("%0d runs split at the count limit, one receiver hold-off of %0d cycles",
             limit_splits, HOLD_CYCLES);
    if (errors == 0 && pending_pairs.size() == 0) begin
      $display("tb_byte_run_length_encoder: done, clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb_byte_run_length_encoder: done, errors");
    end
    $finish;
  end

endmodule
